FILE: rtl/riff_wave_header_parser_macros.svh
// Assertion macros for the checker of the WAV header parser.
`ifndef RIFF_WAVE_HEADER_PARSER_MACROS_SVH
`define RIFF_WAVE_HEADER_PARSER_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define RWH_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion on the usual clk_i / rst_ni pair.
`define RWH_ASSERT(label, prop, msg) \
  `RWH_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/rwh_pkg.sv
// Types, constants and codes shared by the WAV header parser modules.
package rwh_pkg;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [5:0]  MinFileBytes = 6'd44;
  localparam logic [31:0] FmtMinLen    = 32'd16;
  localparam logic [31:0] FmtExtLen    = 32'd18;
  localparam int unsigned FmtBytes     = 18;
  localparam int unsigned FmtBits      = FmtBytes * 8;
  localparam logic [4:0]  ChdrLastOff  = 5'd7;
  localparam logic [4:0]  TagBytes     = 5'd4;

  localparam logic [15:0] FmtTagPcm   = 16'd1;
  localparam logic [15:0] FmtTagFloat = 16'd3;

  localparam logic [15:0] MaxChannelsReset  = 16'd64;
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhChdr   = 3'd1,
    PhFmt    = 3'd2,
    PhData   = 3'd3,
    PhOther  = 3'd4,
    PhPad    = 3'd5,
    PhStop   = 3'd6
  } rwh_phase_e;

  typedef enum logic [1:0] {
    KindAudio  = 2'd0,
    KindFirst  = 2'd1,
    KindReport = 2'd2
  } rwh_kind_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StShort     = 3'd1,
    StNotRiff   = 3'd2,
    StPastEnd   = 3'd3,
    StFmtShort  = 3'd4,
    StEncoding  = 3'd5,
    StBadValues = 3'd6,
    StMissing   = 3'd7
  } rwh_status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } rwh_in_t;

  typedef struct packed {
    rwh_kind_e   kind;
    logic [7:0]  audio_byte;
    rwh_status_e status;
    logic [15:0] format_tag;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [15:0] extra_size;
    logic        last;
  } rwh_out_t;

  // fmt payload bytes 0..17, little-endian: byte k sits at bits [8k+7:8k]
  typedef struct packed {
    logic [15:0] extra_size;
    logic [15:0] bits_per_sample;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [15:0] channels;
    logic [15:0] format_tag;
  } rwh_fmt_t;

  // Everything one input beat produces, queued as a single entry
  typedef struct packed {
    logic        has_audio;
    logic        audio_first;
    logic [7:0]  audio_byte;
    logic        has_report;
    rwh_status_e status;
    rwh_fmt_t    fmt;
  } rwh_entry_t;

endpackage

FILE: rtl/rwh_parser.sv
// Byte-wise RIFF/WAVE parsing state and per-beat result generation.
module rwh_parser
  import rwh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_fire_i,
  input  rwh_in_t     in_data_i,
  input  logic [15:0] max_channels_i,
  output logic        push_o,
  output rwh_entry_t  entry_o
);

  logic [5:0]         cnt_q, cnt_d;
  rwh_phase_e         phase_q, phase_d;
  logic [31:0]        tag_q, tag_d;
  logic [31:0]        len_q, len_d;
  logic [31:0]        left_q, left_d;
  logic [4:0]         off_q, off_d;
  logic [FmtBits-1:0] fmt_q, fmt_d;
  logic               found_fmt_q, found_fmt_d;
  logic               found_audio_q, found_audio_d;
  logic               hdr_ok_q, hdr_ok_d;
  rwh_status_e        err_q, err_d;

  logic               finish;
  rwh_status_e        fmt_err;
  rwh_status_e        rep_status;
  logic [7:0]         b;

  function automatic rwh_status_e check_fmt(rwh_fmt_t f, logic [31:0] len,
                                            logic [15:0] maxc);
    rwh_status_e r;
    r = StOk;
    if (len < FmtMinLen) begin
      r = StFmtShort;
    end else if (f.format_tag != FmtTagPcm && f.format_tag != FmtTagFloat) begin
      r = StEncoding;
    end else if (f.channels == '0 || f.channels > maxc ||
                 f.sample_rate == '0 || f.block_align == '0) begin
      r = StBadValues;
    end
    return r;
  endfunction

  assign b = in_data_i.in_byte;

  always_comb begin
    cnt_d         = cnt_q;
    phase_d       = phase_q;
    tag_d         = tag_q;
    len_d         = len_q;
    left_d        = left_q;
    off_d         = off_q;
    fmt_d         = fmt_q;
    found_fmt_d   = found_fmt_q;
    found_audio_d = found_audio_q;
    hdr_ok_d      = hdr_ok_q;
    err_d         = err_q;
    finish        = 1'b0;
    fmt_err       = StOk;
    rep_status    = StOk;
    entry_o       = '0;
    push_o        = 1'b0;

    if (in_fire_i) begin
      cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + 6'd1;

      case (phase_q)
        PhHeader: begin
          tag_d = {b, tag_q[31:8]};
          if (cnt_q == 6'd3) begin
            hdr_ok_d = (tag_d == TagRiff);
          end
          if (cnt_q == 6'd11) begin
            if (hdr_ok_q && tag_d == TagWave) begin
              phase_d = PhChdr;
              off_d   = '0;
            end else begin
              hdr_ok_d = 1'b0;
              phase_d  = PhStop;
            end
          end
        end
        PhChdr: begin
          if (off_q < TagBytes) begin
            tag_d = {b, tag_q[31:8]};
          end else begin
            len_d = {b, len_q[31:8]};
          end
          off_d = off_q + 5'd1;
          if (off_q == ChdrLastOff) begin
            off_d  = '0;
            left_d = len_d;
            if (tag_q == TagFmt) begin
              fmt_d   = '0;
              phase_d = PhFmt;
            end else if (tag_q == TagData) begin
              found_audio_d = (len_d != '0);
              phase_d       = PhData;
            end else begin
              phase_d = PhOther;
            end
            finish = (len_d == '0);
          end
        end
        PhFmt: begin
          if (off_q < 5'(FmtBytes)) begin
            fmt_d[{off_q, 3'b000} +: 8] = b;
            off_d = off_q + 5'd1;
          end
          left_d = left_q - 32'd1;
          finish = (left_d == '0);
        end
        PhData: begin
          entry_o.has_audio   = 1'b1;
          entry_o.audio_first = (left_q == len_q);
          entry_o.audio_byte  = b;
          left_d = left_q - 32'd1;
          finish = (left_d == '0);
        end
        PhOther: begin
          left_d = left_q - 32'd1;
          finish = (left_d == '0);
        end
        PhPad: begin
          phase_d = PhChdr;
          off_d   = '0;
        end
        default: begin
        end
      endcase

      // Close the chunk: validate fmt, then skip the pad byte on odd lengths
      fmt_err = check_fmt(rwh_fmt_t'(fmt_d), len_d, max_channels_i);
      if (finish) begin
        if (phase_d == PhFmt && fmt_err != StOk) begin
          err_d   = fmt_err;
          phase_d = PhStop;
        end else begin
          if (phase_d == PhFmt) begin
            if (len_d < FmtExtLen) begin
              fmt_d[FmtBits-1 -: 16] = '0;
            end
            found_fmt_d = 1'b1;
          end
          off_d   = '0;
          phase_d = len_d[0] ? PhPad : PhChdr;
        end
      end

      if (in_data_i.in_last) begin
        if ((phase_d == PhFmt || phase_d == PhData || phase_d == PhOther) &&
            left_d != '0 && err_d == StOk) begin
          err_d = StPastEnd;
        end
        if (cnt_d < MinFileBytes) begin
          rep_status = StShort;
        end else if (!hdr_ok_d) begin
          rep_status = StNotRiff;
        end else if (err_d != StOk) begin
          rep_status = err_d;
        end else if (!found_fmt_d || !found_audio_d) begin
          rep_status = StMissing;
        end
        entry_o.has_report = 1'b1;
        entry_o.status     = rep_status;
        entry_o.fmt        = rwh_fmt_t'(fmt_d);

        // Return to the start-of-file state for the next run
        cnt_d         = '0;
        phase_d       = PhHeader;
        tag_d         = '0;
        len_d         = '0;
        left_d        = '0;
        off_d         = '0;
        fmt_d         = '0;
        found_fmt_d   = 1'b0;
        found_audio_d = 1'b0;
        hdr_ok_d      = 1'b0;
        err_d         = StOk;
      end

      push_o = entry_o.has_audio | entry_o.has_report;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      phase_q       <= PhHeader;
      tag_q         <= '0;
      len_q         <= '0;
      left_q        <= '0;
      off_q         <= '0;
      fmt_q         <= '0;
      found_fmt_q   <= 1'b0;
      found_audio_q <= 1'b0;
      hdr_ok_q      <= 1'b0;
      err_q         <= StOk;
    end else begin
      cnt_q         <= cnt_d;
      phase_q       <= phase_d;
      tag_q         <= tag_d;
      len_q         <= len_d;
      left_q        <= left_d;
      off_q         <= off_d;
      fmt_q         <= fmt_d;
      found_fmt_q   <= found_fmt_d;
      found_audio_q <= found_audio_d;
      hdr_ok_q      <= hdr_ok_d;
      err_q         <= err_d;
    end
  end

endmodule

FILE: rtl/rwh_fifo.sv
// Small result queue between the parser and the output serialiser.
module rwh_fifo
  import rwh_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rwh_entry_t entry_i,
  input  logic       pop_i,
  output logic       space_o,
  output logic       valid_o,
  output rwh_entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rwh_entry_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign space_o = (count_q < CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    // Wrap at the last entry so any depth works
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/rwh_emit.sv
// Output serialiser: turns a queued entry into one or two result beats.
module rwh_emit
  import rwh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  rwh_entry_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rwh_out_t   out_data_o
);

  logic sub_q, sub_d;
  logic show_audio;
  logic final_beat;
  logic fire;

  assign show_audio  = head_i.has_audio && !sub_q;
  assign final_beat  = !(head_i.has_audio && head_i.has_report && !sub_q);
  assign out_valid_o = valid_i;
  assign fire        = valid_i && out_ready_i;
  assign pop_o       = fire && final_beat;

  always_comb begin
    sub_d = sub_q;
    if (fire) begin
      sub_d = !final_beat;
    end
  end

  always_comb begin
    out_data_o = '0;
    if (show_audio) begin
      out_data_o.kind       = head_i.audio_first ? KindFirst : KindAudio;
      out_data_o.audio_byte = head_i.audio_byte;
      out_data_o.status     = StOk;
    end else begin
      out_data_o.kind            = KindReport;
      out_data_o.status          = head_i.status;
      out_data_o.format_tag      = head_i.fmt.format_tag;
      out_data_o.channels        = head_i.fmt.channels;
      out_data_o.sample_rate     = head_i.fmt.sample_rate;
      out_data_o.byte_rate       = head_i.fmt.byte_rate;
      out_data_o.block_align     = head_i.fmt.block_align;
      out_data_o.bits_per_sample = head_i.fmt.bits_per_sample;
      out_data_o.extra_size      = head_i.fmt.extra_size;
      out_data_o.last            = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule

FILE: rtl/riff_wave_header_parser.sv
// Top level of the streaming RIFF/WAVE header parser.
//
// Usage: feed the file one byte per beat on the in channel (in_byte, with
// in_last high on the final byte). Every byte of a data chunk comes back as
// one beat on the out channel (kind audio, or kind first for the opening
// byte of each data chunk). The final byte adds one report beat (kind
// report, last high) with the status and the captured fmt fields.
// Each result is registered in the result queue before it is offered.
// Throughput: one byte per cycle while the queue has room; a byte that yields
// both an audio beat and the report sends the audio beat first, then the report.
// The parser state advances in the accepting cycle; results wait in a
// QueueDepth-entry queue, so in_ready_o stays high while the queue has room
// even when the receiver stalls. A full queue drops in_ready_o.
// Reset: all parse state returns to the start of a file, the queue empties
// and max_channels returns to 64. After each report the parse state returns
// to the start of a file by itself.
// Configuration: cfg_data_i writes max_channels; the port always takes the
// beat, and writes belong between files.
module riff_wave_header_parser
  import rwh_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rwh_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rwh_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] max_ch_q, max_ch_d;
  logic        in_fire;
  logic        push;
  rwh_entry_t  entry;
  logic        q_space;
  logic        q_valid;
  rwh_entry_t  q_head;
  logic        pop;

  // Hold the channel limit; take a config beat whenever it comes
  assign cfg_ready_o = 1'b1;
  assign max_ch_d    = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : max_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ch_q <= MaxChannelsReset;
    end else begin
      max_ch_q <= max_ch_d;
    end
  end

  // Accept a byte whenever the result queue can hold one more entry
  assign in_ready_o = q_space;
  assign in_fire    = in_valid_i && in_ready_o;

  rwh_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .in_data_i      (in_data_i),
    .max_channels_i (max_ch_q),
    .push_o         (push),
    .entry_o        (entry)
  );

  rwh_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .space_o (q_space),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // Split an entry into its audio beat and report beat
  rwh_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .head_i      (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/rwh_checker.sv
// Port-level checks on the WAV header parser, bound to its top level.
`include "riff_wave_header_parser_macros.svh"

module rwh_checker
  import rwh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  rwh_in_t     in_data_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  rwh_out_t    out_data_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  `RWH_ASSERT(a_in_hold, (in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i)), "in beat changed while waiting")

  `RWH_ASSERT(a_cfg_hold, (cfg_valid_i && !cfg_ready_o |=> cfg_valid_i && $stable(cfg_data_i)), "cfg beat changed while waiting")

  `RWH_ASSERT(a_out_hold, (out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o)), "out beat changed while stalled")

  `RWH_ASSERT(a_last_is_report, (out_valid_o |-> ((out_data_o.kind == KindReport) == out_data_o.last)), "last flag does not match report kind")

  `RWH_ASSERT(a_audio_clean, (out_valid_o && out_data_o.kind != KindReport |-> out_data_o.status == StOk && out_data_o.format_tag == '0 && out_data_o.sample_rate == '0), "audio beat carries report fields")

endmodule

bind riff_wave_header_parser rwh_checker u_rwh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);

FILE: tb/sv/riff_wave_header_parser_tb.sv
// Self-checking testbench for the streaming RIFF/WAVE header parser.
`timescale 1ns / 100ps

module riff_wave_header_parser_tb;
  import rwh_pkg::*;

  // "JUNK": an id that is neither fmt nor data, so the parser skips the chunk
  localparam logic [31:0] JunkTag    = 32'h4B4E_554A;
  localparam int          ByteBudget = 1850;
  localparam int          NumPhases  = 4;

  // Mirror of the parser: runs the same walk over the byte stream, queues
  // the beats that each accepted byte must produce and matches them in order.
  class wav_stream_scoreboard;
    logic [15:0]         max_channels;
    rwh_out_t            expected_beats[$];
    int unsigned         errors;
    logic [31:0]         byte_count;
    logic [31:0]         tag_shift;
    logic [31:0]         chunk_length;
    logic [31:0]         bytes_left;
    rwh_phase_e          phase;
    logic                pad_pending;
    logic [4:0]          chunk_offset;
    logic [FmtBits-1:0]  fmt_bits;
    bit                  found_format;
    bit                  found_audio;
    bit                  header_ok;
    rwh_status_e         first_error;

    function new();
      max_channels = MaxChannelsReset;
      errors = 0;
      restart();
    endfunction

    function void restart();
      byte_count = '0;
      tag_shift = '0;
      chunk_length = '0;
      bytes_left = '0;
      phase = PhHeader;
      pad_pending = 1'b0;
      chunk_offset = '0;
      fmt_bits = '0;
      found_format = 0;
      found_audio = 0;
      header_ok = 0;
      first_error = StOk;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function rwh_status_e fmt_verdict();
      rwh_fmt_t f;
      f = rwh_fmt_t'(fmt_bits);
      if (chunk_length < FmtMinLen) return StFmtShort;
      if (f.format_tag != FmtTagPcm && f.format_tag != FmtTagFloat) return StEncoding;
      if (f.channels == 16'd0 || f.channels > max_channels || f.sample_rate == 32'd0 ||
          f.block_align == 16'd0) return StBadValues;
      return StOk;
    endfunction

    // End of a chunk payload: validate fmt, then head for the pad or the next header
    function void close_chunk();
      rwh_status_e verdict;
      if (phase == PhFmt) begin
        verdict = fmt_verdict();
        if (verdict != StOk) begin
          first_error = verdict;
          phase = PhStop;
          return;
        end
        if (chunk_length < FmtExtLen) fmt_bits[FmtBits-1 -: 16] = '0;
        found_format = 1;
      end
      chunk_offset = '0;
      pad_pending = chunk_length[0];
      phase = pad_pending ? PhPad : PhChdr;
    endfunction

    function void queue_beat(rwh_kind_e kind, logic [7:0] data, rwh_status_e st,
                             bit is_report);
      rwh_out_t beat;
      rwh_fmt_t f;
      f = is_report ? rwh_fmt_t'(fmt_bits) : rwh_fmt_t'('0);
      beat.kind            = kind;
      beat.audio_byte      = data;
      beat.status          = st;
      beat.format_tag      = f.format_tag;
      beat.channels        = f.channels;
      beat.sample_rate     = f.sample_rate;
      beat.byte_rate       = f.byte_rate;
      beat.block_align     = f.block_align;
      beat.bits_per_sample = f.bits_per_sample;
      beat.extra_size      = f.extra_size;
      beat.last            = is_report;
      expected_beats.insert(expected_beats.size(), beat);
    endfunction

    // Advance the walk by one accepted input beat
    function void take_byte(rwh_in_t beat);
      logic [31:0] pos;
      logic [7:0]  b;
      rwh_status_e st;
      b = beat.in_byte;
      pos = byte_count;
      if (byte_count != '1) byte_count++;
      case (phase)
        PhHeader: begin
          tag_shift = {b, tag_shift[31:8]};
          if (pos == 32'd3) header_ok = (tag_shift == TagRiff);
          if (pos == 32'd11) begin
            if (header_ok && tag_shift == TagWave) begin
              phase = PhChdr;
              chunk_offset = '0;
            end else begin
              header_ok = 0;
              phase = PhStop;
            end
          end
        end
        PhChdr: begin
          if (chunk_offset < TagBytes) tag_shift = {b, tag_shift[31:8]};
          else chunk_length = {b, chunk_length[31:8]};
          chunk_offset++;
          if (chunk_offset > ChdrLastOff) begin
            chunk_offset = '0;
            bytes_left = chunk_length;
            if (tag_shift == TagFmt) begin
              fmt_bits = '0;
              phase = PhFmt;
            end else if (tag_shift == TagData) begin
              found_audio = (chunk_length != 32'd0);
              phase = PhData;
            end else begin
              phase = PhOther;
            end
            if (chunk_length == 32'd0) close_chunk();
          end
        end
        PhFmt: begin
          if (chunk_offset < FmtBytes) begin
            fmt_bits[chunk_offset*8 +: 8] = b;
            chunk_offset++;
          end
          bytes_left--;
          if (bytes_left == 32'd0) close_chunk();
        end
        PhData: begin
          queue_beat(bytes_left == chunk_length ? KindFirst : KindAudio, b, StOk, 0);
          bytes_left--;
          if (bytes_left == 32'd0) close_chunk();
        end
        PhOther: begin
          bytes_left--;
          if (bytes_left == 32'd0) close_chunk();
        end
        PhPad: begin
          pad_pending = 1'b0;
          phase = PhChdr;
          chunk_offset = '0;
        end
        default: ;
      endcase

      if (beat.in_last) begin
        if ((phase == PhFmt || phase == PhData || phase == PhOther) &&
            bytes_left != 32'd0 && first_error == StOk) first_error = StPastEnd;
        if (byte_count < MinFileBytes)              st = StShort;
        else if (!header_ok)                        st = StNotRiff;
        else if (first_error != StOk)               st = first_error;
        else if (!found_format || !found_audio)     st = StMissing;
        else                                        st = StOk;
        queue_beat(KindReport, 8'h00, st, 1);
        restart();
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    // Match one accepted output beat against the oldest expectation
    function void match_result(rwh_out_t got);
      rwh_out_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got kind %0d byte %0h status %0d",
                 $time, got.kind, got.audio_byte, got.status);
        return;
      end
      want = expected_beats.pop_front();
      compare_field("kind",            want.kind,            got.kind);
      compare_field("audio_byte",      want.audio_byte,      got.audio_byte);
      compare_field("status",          want.status,          got.status);
      compare_field("format_tag",      want.format_tag,      got.format_tag);
      compare_field("channels",        want.channels,        got.channels);
      compare_field("sample_rate",     want.sample_rate,     got.sample_rate);
      compare_field("byte_rate",       want.byte_rate,       got.byte_rate);
      compare_field("block_align",     want.block_align,     got.block_align);
      compare_field("bits_per_sample", want.bits_per_sample, got.bits_per_sample);
      compare_field("extra_size",      want.extra_size,      got.extra_size);
      compare_field("last",            want.last,            got.last);
    endfunction

    function void flag_leftovers();
      foreach (expected_beats[i]) begin
        errors++;
        $display("%0t: missing beat, expected kind %0d byte %0h status %0d, got none",
                 $time, expected_beats[i].kind, expected_beats[i].audio_byte,
                 expected_beats[i].status);
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  rwh_in_t     in_data   = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rwh_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  wav_stream_scoreboard sb = new();

  logic [7:0]  file_q[$];     // bytes of the file being built
  logic [15:0] cur_max     = MaxChannelsReset;
  int          send_idle   = 0;  // percent of cycles the sender sits idle
  int          recv_stall  = 0;  // percent of cycles the receiver stalls
  int          hold_left   = 0;  // long receiver hold-off, in cycles
  int          sent_bytes  = 0;

  riff_wave_header_parser u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // Sample both channels at the rising edge; results are checked before the
  // byte of the same edge is noted, which cannot reorder anything because a
  // result is always registered in the result queue before it is offered.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.match_result(out_data);
      if (in_valid && in_ready) sb.take_byte(in_data);
    end
  end

  // Receiver: honour a pending hold-off first, otherwise stall at random
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Hard stop in case the block locks up
  initial begin
    #2_000_000;
    $display("FAIL riff_wave_header_parser");
    $finish;
  end

  // Append one byte to the file being built
  function automatic void add_byte(input logic [7:0] value);
    file_q.insert(file_q.size(), value);
  endfunction

  function automatic void push_le(input logic [31:0] value, input int n);
    for (int i = 0; i < n; i++) add_byte(value[8*i +: 8]);
  endfunction

  // Random payload, plus the pad byte after an odd length
  function automatic void push_payload(input int len);
    for (int i = 0; i < len + (len % 2); i++) add_byte(8'($urandom));
  endfunction

  // Build a file: header, then optional junk, fmt, data and a second data
  // chunk, in that order. A negative length leaves the chunk out.
  function automatic void build_wav(input int other_len, input int fmt_len,
                                    input logic [15:0] tag, input logic [15:0] chans,
                                    input logic [31:0] rate, input logic [15:0] align,
                                    input int data_len, input int later_len);
    rwh_fmt_t           f;
    logic [FmtBits-1:0] fb;
    push_le(TagRiff, 4);
    push_le($urandom, 4);
    push_le(TagWave, 4);
    if (other_len >= 0) begin
      push_le(JunkTag, 4);
      push_le(other_len, 4);
      push_payload(other_len);
    end
    if (fmt_len >= 0) begin
      f.format_tag      = tag;
      f.channels        = chans;
      f.sample_rate     = rate;
      f.byte_rate       = $urandom;
      f.block_align     = align;
      f.bits_per_sample = 16'($urandom);
      f.extra_size      = 16'($urandom);
      fb = f;
      push_le(TagFmt, 4);
      push_le(fmt_len, 4);
      for (int k = 0; k < fmt_len; k++)
        add_byte(k < FmtBytes ? fb[k*8 +: 8] : 8'($urandom));
      if (fmt_len % 2) add_byte(8'($urandom));
    end
    if (data_len >= 0) begin
      push_le(TagData, 4);
      push_le(data_len, 4);
      push_payload(data_len);
    end
    if (later_len >= 0) begin
      push_le(TagData, 4);
      push_le(later_len, 4);
      push_payload(later_len);
    end
  endfunction

  function automatic void cut_to(input int n);
    while (file_q.size() > n) void'(file_q.pop_back());
  endfunction

  // Offer one byte; hold it until the parser takes it
  task automatic offer_byte(input logic [7:0] b, input logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: is_last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) offer_byte(file_q[i], i == file_q.size() - 1);
    sent_bytes += file_q.size();
    file_q.delete();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_channels(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.max_channels = value;
    cur_max = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hand-picked files: each status, the capture limits and the odd corners
  task automatic run_directed();
    add_byte(8'hFF);                               // one-byte file
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 5, -1);  // clean, odd data
    send_file();
    build_wav(3, 18, FmtTagFloat, 16'd64, 32'd48000, 16'd8, 7, -1); // junk, ext size
    send_file();
    build_wav(-1, 40, FmtTagPcm, 16'd1, 32'd1, 16'd1, 2, -1);  // fmt longer than captured
    send_file();
    build_wav(-1, 14, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 4, -1); // fmt too short
    send_file();
    build_wav(-1, 0, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 4, -1);  // empty fmt
    send_file();
    build_wav(-1, 16, 16'd2, 16'd2, 32'd8000, 16'd4, 6, -1);     // encoding, bytes after
    send_file();
    build_wav(-1, 16, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 2, -1);
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd0, 32'd8000, 16'd4, 4, -1); // no channels
    send_file();
    build_wav(-1, 16, FmtTagPcm, cur_max + 16'd1, 32'd8000, 16'd4, 4, -1);
    send_file();
    build_wav(-1, 16, FmtTagFloat, 16'd2, 32'd0, 16'd4, 4, -1);  // zero rate
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd0, 4, -1); // zero block align
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, -1, -1); // no data chunk
    send_file();
    build_wav(1, -1, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 8, -1);   // no fmt chunk
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 4, 0);   // later empty data
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 0, -1);  // only empty data
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 3, 4);   // two data chunks
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 4, -1);  // bad RIFF tag
    file_q[0] = 8'h00;
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 4, -1);  // bad WAVE tag
    file_q[11] = file_q[11] ^ 8'h01;
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 4, -1);  // under 44 bytes
    cut_to(43);
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 10, -1); // ends inside data
    cut_to(file_q.size() - 3);
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 5, -1);  // pad byte missing
    cut_to(file_q.size() - 1);
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 4, -1);  // partial trailer
    push_le(JunkTag, 4);
    push_le(32'd6, 1);
    send_file();
    build_wav(-1, 16, FmtTagPcm, 16'd2, 32'd8000, 16'd4, 4, -1);  // huge junk chunk
    push_le(JunkTag, 4);
    push_le(32'hFFFF_FFFF, 4);
    push_le($urandom, 3);
    send_file();
  endtask

  // Mostly well-formed files with random content, some damaged, some noise
  task automatic make_random_file();
    int          sel;
    int          fmt_len;
    logic [15:0] tag;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] align;
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(1)) begin
        push_le(TagRiff, 4);
        push_le($urandom, 4);
        push_le(TagWave, 4);
      end
      push_le($urandom, 0);
      for (int i = $urandom_range(60, 1); i > 0; i--) add_byte(8'($urandom));
      return;
    end
    sel = $urandom_range(9);
    if (sel < 4)       fmt_len = 16;
    else if (sel < 7)  fmt_len = 18;
    else if (sel == 7) fmt_len = $urandom_range(15);
    else               fmt_len = $urandom_range(40, 17);
    sel = $urandom_range(19);
    tag = (sel < 9) ? FmtTagPcm : (sel < 18) ? FmtTagFloat : 16'($urandom);
    case ($urandom_range(7))
      0:       chans = 16'd0;
      1:       chans = cur_max;
      2:       chans = cur_max + 16'd1;   // wraps to zero at the top setting
      3:       chans = 16'd1;
      default: chans = 16'($urandom_range(cur_max, 1));
    endcase
    rate  = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
    align = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(65535, 1));
    build_wav(($urandom_range(9) < 3) ? $urandom_range(9) : -1, fmt_len, tag, chans,
              rate, align, ($urandom_range(9) != 0) ? $urandom_range(24) : -1,
              ($urandom_range(99) < 15) ? $urandom_range(6) : -1);
    if ($urandom_range(9) == 0) cut_to($urandom_range(file_q.size(), 1));
    if ($urandom_range(19) == 0) file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
    if ($urandom_range(9) == 0) push_le($urandom, $urandom_range(4, 1));
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Each phase: own idling pattern and channel limit, written while idle
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 61; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 61; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      if (p > 0) begin
        drain_results();
        case (p)
          1: write_max_channels(16'd1);
          2: write_max_channels(16'hFFFF);
          default: write_max_channels(16'($urandom_range(65534, 2)));
        endcase
      end
      if (p == 0) run_directed();
      // Hold the receiver off long enough for the result queue to fill and
      // back-pressure the byte stream
      if (p == 2) hold_left = 400;
      // Share what is left of the byte budget among the remaining phases
      target = sent_bytes + (ByteBudget - sent_bytes) / (NumPhases - p);
      while (sent_bytes < target) begin
        make_random_file();
        send_file();
      end
    end

    drain_results();
    sb.flag_leftovers();
    if (sb.errors == 0) $display("PASS riff_wave_header_parser");
    else $display("FAIL riff_wave_header_parser");
    $finish;
  end

endmodule
